// File: hw/rtl/swbt_pkg.sv
// swbt_pkg: shared types and constants for the sliding-window ban tracker
// request and response word layouts, opcodes, register indexes
// no dependencies
package swbt_pkg;

	localparam int KEY_W  = 64;
	localparam int TIME_W = 32;
	localparam int EXP_W  = 33;
	localparam int REM_W  = 20;
	localparam int MAXA_W = 5;
	localparam int WIN_W  = 17;
	localparam int BAN_W  = 20;
	localparam int CFG_W  = 20;

	localparam logic [REM_W-1:0] REM_MAX = '1;

	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_SWEEP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_MAX_ATTEMPTS   = 2'd0,
		REG_WINDOW_SECONDS = 2'd1,
		REG_BAN_SECONDS    = 2'd2,
		REG_UNUSED         = 2'd3
	} reg_idx_t;

	localparam logic [MAXA_W-1:0] MAXA_RST = MAXA_W'(5);
	localparam logic [WIN_W-1:0]  WIN_RST  = WIN_W'(60);
	localparam logic [BAN_W-1:0]  BAN_RST  = BAN_W'(300);

	typedef struct packed {
		logic [1:0]        opcode;
		logic [KEY_W-1:0]  client_key;
		logic [TIME_W-1:0] current_time;
	} req_word_t;

	typedef struct packed {
		logic              banned;
		logic [REM_W-1:0]  ban_remaining;
		logic              key_found;
		logic              table_full;
	} rsp_word_t;

endpackage

// File: hw/rtl/sliding_window_ban_tracker.sv
// sliding_window_ban_tracker: top level of the per-client ban tracker
// key, entry-state and attempt-time memories driven by one sequencer
// depends on swbt_pkg
//
// One request word in, one response word out, one at a time. A request word
// is taken in the idle state. Record, query and clear first scan the key
// memory one entry per cycle, comparing each read in the next cycle; a miss
// is known in the cycle after the last compare. A query then reads and checks
// the entry state; a clear goes straight to the output state. A record reads
// the entry state (not for a newly taken entry), appends the attempt, purges
// and writes the entry state back. The purge walks the attempt ring through
// the time memory, read then check/write-back for each attempt held after
// the append. A sweep visits every entry: it skips a free one, frees one
// whose ban has expired and purges a live one, writing its state back. Every
// request then passes through the output state, which hands its word to the
// output register, waiting while the previous word there is stalled. The
// response sits in that register, so the next request word is taken as soon
// as the sequencer is back in idle, even while the last response is stalled.
// Valid bits live in flip-flops and are cleared by reset, so no clearing
// pass runs after reset. Configuration writes are always accepted.
module sliding_window_ban_tracker #(
	parameter int TABLE_ENTRIES = 64,
	parameter int HISTORY_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request word channel
	input  logic                       req_valid,
	output logic                       req_stall,
	input  swbt_pkg::req_word_t        req,
	// response word channel
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output swbt_pkg::rsp_word_t        rsp,
	// configuration write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [swbt_pkg::CFG_W-1:0] cfg_data
);

	localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int SCAN_W  = IDX_W + 1;
	localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int CMP_W   = (CNT_W > swbt_pkg::MAXA_W) ? CNT_W : swbt_pkg::MAXA_W;
	localparam int TDEPTH  = TABLE_ENTRIES * HISTORY_DEPTH;
	localparam int TADDR_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

	// per-entry state kept in the entry memory
	typedef struct packed {
		logic [swbt_pkg::EXP_W-1:0] expiry;
		logic [CNT_W-1:0]           cnt;
		logic [SLOT_W-1:0]          head;
	} meta_t;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_SRCH = 14'b00000000000010,
		ST_QRD  = 14'b00000000000100,
		ST_QCHK = 14'b00000000001000,
		ST_RRD  = 14'b00000000010000,
		ST_RLD  = 14'b00000000100000,
		ST_APND = 14'b00000001000000,
		ST_PRD  = 14'b00000010000000,
		ST_PCHK = 14'b00000100000000,
		ST_RFIN = 14'b00001000000000,
		ST_SNXT = 14'b00010000000000,
		ST_SLD  = 14'b00100000000000,
		ST_SFIN = 14'b01000000000000,
		ST_OUT  = 14'b10000000000000
	} state_t;

	// ring slot arithmetic, both operands below the depth
	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
		input logic [SLOT_W-1:0] b);
		logic [SLOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (SLOT_W+1)'(HISTORY_DEPTH)) begin
			s = s - (SLOT_W+1)'(HISTORY_DEPTH);
		end
		return s[SLOT_W-1:0];
	endfunction

	function automatic logic [TADDR_W-1:0] taddr(input logic [IDX_W-1:0] e,
		input logic [SLOT_W-1:0] s);
		return TADDR_W'(e) * TADDR_W'(HISTORY_DEPTH) + TADDR_W'(s);
	endfunction

	state_t                       state_q;

	// configuration registers
	logic [swbt_pkg::MAXA_W-1:0]  max_q;
	logic [swbt_pkg::WIN_W-1:0]   win_q;
	logic [swbt_pkg::BAN_W-1:0]   ban_q;

	// captured request
	swbt_pkg::op_t                op_q;
	logic [swbt_pkg::KEY_W-1:0]   key_q;
	logic [swbt_pkg::TIME_W-1:0]  now_q;

	// entry valid bits
	logic [TABLE_ENTRIES-1:0]     valid_q;

	// key scan
	logic [SCAN_W-1:0]            scan_idx_q;
	logic                         chk_vld_s1;
	logic [IDX_W-1:0]             chk_idx_s1;
	logic                         free_fnd_q;
	logic [IDX_W-1:0]             free_idx_q;

	// working copy of the entry
	logic [IDX_W-1:0]             ent_q;
	logic [swbt_pkg::EXP_W-1:0]   exp_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [SLOT_W-1:0]            head_q;
	logic [CNT_W-1:0]             k_q;
	logic [CNT_W-1:0]             kept_q;
	logic [SCAN_W-1:0]            sw_idx_q;

	// response under construction and output register
	logic                         banned_q;
	logic [swbt_pkg::REM_W-1:0]   rem_q;
	logic                         found_q;
	logic                         full_q;
	logic                         rsp_valid_q;
	swbt_pkg::rsp_word_t          rsp_q;

	// memories
	logic [swbt_pkg::KEY_W-1:0]   key_mem [TABLE_ENTRIES];
	meta_t                        meta_mem [TABLE_ENTRIES];
	logic [swbt_pkg::TIME_W-1:0]  time_mem [TDEPTH];
	logic [swbt_pkg::KEY_W-1:0]   key_rd_q;
	meta_t                        meta_rd_q;
	logic [swbt_pkg::TIME_W-1:0]  time_rd_q;

	logic                         key_re, key_we;
	logic [IDX_W-1:0]             key_ra;
	logic                         meta_re, meta_we;
	logic [IDX_W-1:0]             meta_ra;
	meta_t                        meta_wd;
	logic                         time_re, time_we;
	logic [TADDR_W-1:0]           time_ra, time_wa;
	logic [swbt_pkg::TIME_W-1:0]  time_wd;

	logic                         scan_done, sw_done;
	logic                         hit, miss;
	logic                         keep;
	logic                         ban_hit;
	logic [swbt_pkg::EXP_W-1:0]   exp_new;
	logic [swbt_pkg::EXP_W-1:0]   now_ext;
	logic [swbt_pkg::EXP_W-1:0]   q_diff;
	logic                         expired;
	logic [SLOT_W-1:0]            app_slot;

	assign now_ext   = {1'b0, now_q};
	assign scan_done = (scan_idx_q == SCAN_W'(TABLE_ENTRIES));
	assign sw_done   = (sw_idx_q == SCAN_W'(TABLE_ENTRIES));
	assign hit       = chk_vld_s1 && valid_q[chk_idx_s1] && (key_rd_q == key_q);
	assign miss      = !chk_vld_s1 && scan_done;

	// an attempt stays while t + window >= now
	assign keep = ({1'b0, time_rd_q} + swbt_pkg::EXP_W'(win_q)) >= now_ext;

	assign ban_hit = CMP_W'(cnt_q) >= CMP_W'(max_q);
	assign exp_new = ban_hit ? (now_ext + swbt_pkg::EXP_W'(ban_q)) : exp_q;
	assign q_diff  = meta_rd_q.expiry - now_ext;
	assign expired = (meta_rd_q.expiry != '0) && (meta_rd_q.expiry <= now_ext);

	// a full ring overwrites its oldest slot
	assign app_slot = (cnt_q == CNT_W'(HISTORY_DEPTH)) ? head_q :
		slot_add(head_q, cnt_q[SLOT_W-1:0]);

	// memory port control
	always_comb begin
		key_re  = (state_q == ST_SRCH) && !scan_done;
		key_ra  = scan_idx_q[IDX_W-1:0];
		key_we  = (state_q == ST_SRCH) && !hit && miss && (op_q == swbt_pkg::OP_RECORD)
			&& free_fnd_q;

		meta_re = 1'b0;
		meta_ra = ent_q;
		unique case (state_q)
			ST_QRD, ST_RRD: begin
				meta_re = 1'b1;
			end
			ST_SNXT: begin
				meta_re = !sw_done && valid_q[sw_idx_q[IDX_W-1:0]];
				meta_ra = sw_idx_q[IDX_W-1:0];
			end
			default: begin
				meta_re = 1'b0;
			end
		endcase
		meta_we = (state_q == ST_RFIN) || (state_q == ST_SFIN);
		meta_wd.expiry = (state_q == ST_RFIN) ? exp_new : exp_q;
		meta_wd.cnt    = cnt_q;
		meta_wd.head   = head_q;

		time_re = (state_q == ST_PRD) && (k_q != cnt_q);
		time_ra = taddr(ent_q, slot_add(head_q, k_q[SLOT_W-1:0]));
		time_we = (state_q == ST_APND) || ((state_q == ST_PCHK) && keep);
		time_wa = (state_q == ST_APND) ? taddr(ent_q, app_slot) :
			taddr(ent_q, slot_add(head_q, kept_q[SLOT_W-1:0]));
		time_wd = (state_q == ST_APND) ? now_q : time_rd_q;
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[free_idx_q] <= key_q;
		end
		if (key_re) begin
			key_rd_q <= key_mem[key_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[ent_q] <= meta_wd;
		end
		if (meta_re) begin
			meta_rd_q <= meta_mem[meta_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (time_we) begin
			time_mem[time_wa] <= time_wd;
		end
		if (time_re) begin
			time_rd_q <= time_mem[time_ra];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_q       <= swbt_pkg::MAXA_RST;
			win_q       <= swbt_pkg::WIN_RST;
			ban_q       <= swbt_pkg::BAN_RST;
			valid_q     <= '0;
			op_q        <= swbt_pkg::OP_RECORD;
			key_q       <= '0;
			now_q       <= '0;
			scan_idx_q  <= '0;
			chk_vld_s1  <= 1'b0;
			chk_idx_s1  <= '0;
			free_fnd_q  <= 1'b0;
			free_idx_q  <= '0;
			ent_q       <= '0;
			exp_q       <= '0;
			cnt_q       <= '0;
			head_q      <= '0;
			k_q         <= '0;
			kept_q      <= '0;
			sw_idx_q    <= '0;
			banned_q    <= 1'b0;
			rem_q       <= '0;
			found_q     <= 1'b0;
			full_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// register writes, unused index ignored
			if (cfg_valid) begin
				unique case (swbt_pkg::reg_idx_t'(cfg_index))
					swbt_pkg::REG_MAX_ATTEMPTS:   max_q <= cfg_data[swbt_pkg::MAXA_W-1:0];
					swbt_pkg::REG_WINDOW_SECONDS: win_q <= cfg_data[swbt_pkg::WIN_W-1:0];
					swbt_pkg::REG_BAN_SECONDS:    ban_q <= cfg_data[swbt_pkg::BAN_W-1:0];
					default: begin
					end
				endcase
			end

			// the output state refills the register itself
			if (rsp_valid_q && !rsp_stall && (state_q != ST_OUT)) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q       <= swbt_pkg::op_t'(req.opcode);
						key_q      <= req.client_key;
						now_q      <= req.current_time;
						banned_q   <= 1'b0;
						rem_q      <= '0;
						found_q    <= 1'b0;
						full_q     <= 1'b0;
						scan_idx_q <= '0;
						chk_vld_s1 <= 1'b0;
						free_fnd_q <= 1'b0;
						sw_idx_q   <= '0;
						state_q    <= (swbt_pkg::op_t'(req.opcode) == swbt_pkg::OP_SWEEP) ?
							ST_SNXT : ST_SRCH;
					end
				end
				ST_SRCH: begin
					// one key read issued per cycle, compared in the next cycle
					if (!scan_done) begin
						chk_vld_s1 <= 1'b1;
						chk_idx_s1 <= scan_idx_q[IDX_W-1:0];
						scan_idx_q <= scan_idx_q + 1'b1;
					end else begin
						chk_vld_s1 <= 1'b0;
					end
					// remember the lowest free entry for allocation
					if (chk_vld_s1 && !valid_q[chk_idx_s1] && !free_fnd_q) begin
						free_fnd_q <= 1'b1;
						free_idx_q <= chk_idx_s1;
					end
					if (hit) begin
						ent_q   <= chk_idx_s1;
						found_q <= 1'b1;
						unique case (op_q)
							swbt_pkg::OP_RECORD: state_q <= ST_RRD;
							swbt_pkg::OP_QUERY:  state_q <= ST_QRD;
							default: begin
								valid_q[chk_idx_s1] <= 1'b0;
								state_q             <= ST_OUT;
							end
						endcase
					end else if (miss) begin
						if (op_q == swbt_pkg::OP_RECORD) begin
							if (free_fnd_q) begin
								// fresh entry, state starts empty
								ent_q               <= free_idx_q;
								valid_q[free_idx_q] <= 1'b1;
								exp_q               <= '0;
								cnt_q               <= '0;
								head_q              <= '0;
								state_q             <= ST_APND;
							end else begin
								full_q  <= 1'b1;
								state_q <= ST_OUT;
							end
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_QRD: begin
					state_q <= ST_QCHK;
				end
				ST_QCHK: begin
					if (meta_rd_q.expiry > now_ext) begin
						rem_q <= (q_diff > swbt_pkg::EXP_W'(swbt_pkg::REM_MAX)) ?
							swbt_pkg::REM_MAX : q_diff[swbt_pkg::REM_W-1:0];
					end
					state_q <= ST_OUT;
				end
				ST_RRD: begin
					state_q <= ST_RLD;
				end
				ST_RLD: begin
					exp_q   <= meta_rd_q.expiry;
					cnt_q   <= meta_rd_q.cnt;
					head_q  <= meta_rd_q.head;
					state_q <= ST_APND;
				end
				ST_APND: begin
					// time written by the port control this cycle
					if (cnt_q == CNT_W'(HISTORY_DEPTH)) begin
						head_q <= slot_add(head_q, SLOT_W'(1));
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
					k_q     <= '0;
					kept_q  <= '0;
					state_q <= ST_PRD;
				end
				ST_PRD: begin
					if (k_q == cnt_q) begin
						cnt_q   <= kept_q;
						state_q <= (op_q == swbt_pkg::OP_SWEEP) ? ST_SFIN : ST_RFIN;
					end else begin
						state_q <= ST_PCHK;
					end
				end
				ST_PCHK: begin
					// kept attempts compact toward the head
					if (keep) begin
						kept_q <= kept_q + 1'b1;
					end
					k_q     <= k_q + 1'b1;
					state_q <= ST_PRD;
				end
				ST_RFIN: begin
					exp_q    <= exp_new;
					banned_q <= ban_hit;
					state_q  <= ST_OUT;
				end
				ST_SNXT: begin
					if (sw_done) begin
						state_q <= ST_OUT;
					end else if (!valid_q[sw_idx_q[IDX_W-1:0]]) begin
						sw_idx_q <= sw_idx_q + 1'b1;
					end else begin
						ent_q   <= sw_idx_q[IDX_W-1:0];
						state_q <= ST_SLD;
					end
				end
				ST_SLD: begin
					exp_q  <= meta_rd_q.expiry;
					cnt_q  <= meta_rd_q.cnt;
					head_q <= meta_rd_q.head;
					if (expired) begin
						valid_q[ent_q] <= 1'b0;
						sw_idx_q       <= sw_idx_q + 1'b1;
						state_q        <= ST_SNXT;
					end else begin
						k_q     <= '0;
						kept_q  <= '0;
						state_q <= ST_PRD;
					end
				end
				ST_SFIN: begin
					// idle entry with no ban goes away
					if ((cnt_q == '0) && (exp_q == '0)) begin
						valid_q[ent_q] <= 1'b0;
					end
					sw_idx_q <= sw_idx_q + 1'b1;
					state_q  <= ST_SNXT;
				end
				ST_OUT: begin
					// hand the word over once the output register is free
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.banned        <= banned_q;
						rsp_q.ban_remaining <= rem_q;
						rsp_q.key_found     <= found_q;
						rsp_q.table_full    <= full_q;
						rsp_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

endmodule
